### rtl/imufp_pkg.sv
// ----------------------------------------------------------------------------
// imufp_pkg
// shared types, frame layout constants and decode functions for the imu frame
// parser
// ----------------------------------------------------------------------------
package imufp_pkg;

    localparam int FRAME_LEN = 50;
    localparam int NUM_WORDS = 9;
    localparam int POS_W     = 6;
    localparam int SLOT_W    = 4;
    localparam int WORD_W    = 32;

    localparam logic [POS_W-1:0] POS_HUNT  = 6'd0;
    localparam logic [POS_W-1:0] POS_FIRST = 6'd1;
    localparam logic [POS_W-1:0] POS_END   = 6'(FRAME_LEN - 1);
    localparam logic [POS_W-1:0] POS_LIMIT = 6'(FRAME_LEN);

    localparam logic [POS_W-1:0] POS_BUS      = 6'd1;
    localparam logic [POS_W-1:0] POS_MSG      = 6'd2;
    localparam logic [POS_W-1:0] POS_EUL_ID_H = 6'd4;
    localparam logic [POS_W-1:0] POS_EUL_ID_L = 6'd5;
    localparam logic [POS_W-1:0] POS_EUL_LEN  = 6'd6;
    localparam logic [POS_W-1:0] POS_ACC_ID_H = 6'd19;
    localparam logic [POS_W-1:0] POS_ACC_ID_L = 6'd20;
    localparam logic [POS_W-1:0] POS_ACC_LEN  = 6'd21;
    localparam logic [POS_W-1:0] POS_GYR_ID_H = 6'd34;
    localparam logic [POS_W-1:0] POS_GYR_ID_L = 6'd35;
    localparam logic [POS_W-1:0] POS_GYR_LEN  = 6'd36;

    localparam logic [POS_W-1:0] POS_EUL_DATA = 6'd7;
    localparam logic [POS_W-1:0] POS_EUL_LAST = 6'd18;
    localparam logic [POS_W-1:0] POS_ACC_DATA = 6'd22;
    localparam logic [POS_W-1:0] POS_ACC_LAST = 6'd33;
    localparam logic [POS_W-1:0] POS_GYR_DATA = 6'd37;
    localparam logic [POS_W-1:0] POS_GYR_LAST = 6'd48;

    localparam logic [SLOT_W-1:0] SLOT_EUL = 4'd0;
    localparam logic [SLOT_W-1:0] SLOT_ACC = 4'd3;
    localparam logic [SLOT_W-1:0] SLOT_GYR = 4'd6;

    localparam logic [7:0] BYTE_PREAMBLE = 8'hFA;
    localparam logic [7:0] BYTE_BUS      = 8'hFF;
    localparam logic [7:0] BYTE_MSG      = 8'h36;
    localparam logic [7:0] BYTE_EUL_ID_H = 8'h20;
    localparam logic [7:0] BYTE_EUL_ID_L = 8'h30;
    localparam logic [7:0] BYTE_ACC_ID_H = 8'h40;
    localparam logic [7:0] BYTE_ACC_ID_L = 8'h20;
    localparam logic [7:0] BYTE_GYR_ID_H = 8'h80;
    localparam logic [7:0] BYTE_GYR_ID_L = 8'h20;
    localparam logic [7:0] BYTE_PKT_LEN  = 8'h0C;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    typedef struct packed {
        logic       check;
        logic [7:0] value;
    } t_hdr_check;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] idx;
    } t_slot;

    typedef struct packed {
        logic [NUM_WORDS-1:0][WORD_W-1:0] words;
        logic                             frame_status;
    } t_frame_result;

    function automatic t_hdr_check f_header(input logic [POS_W-1:0] pos);
        t_hdr_check h;
        h.check = 1'b1;
        unique case (pos)
            POS_BUS:      h.value = BYTE_BUS;
            POS_MSG:      h.value = BYTE_MSG;
            POS_EUL_ID_H: h.value = BYTE_EUL_ID_H;
            POS_EUL_ID_L: h.value = BYTE_EUL_ID_L;
            POS_EUL_LEN:  h.value = BYTE_PKT_LEN;
            POS_ACC_ID_H: h.value = BYTE_ACC_ID_H;
            POS_ACC_ID_L: h.value = BYTE_ACC_ID_L;
            POS_ACC_LEN:  h.value = BYTE_PKT_LEN;
            POS_GYR_ID_H: h.value = BYTE_GYR_ID_H;
            POS_GYR_ID_L: h.value = BYTE_GYR_ID_L;
            POS_GYR_LEN:  h.value = BYTE_PKT_LEN;
            default: begin
                h.check = 1'b0;
                h.value = 8'h00;
            end
        endcase
        return h;
    endfunction

    function automatic t_slot f_slot(input logic [POS_W-1:0] pos);
        t_slot            s;
        logic [POS_W-1:0] off;
        s.hit = 1'b1;
        off   = '0;
        s.idx = '0;
        if (pos >= POS_EUL_DATA && pos <= POS_EUL_LAST) begin
            off   = pos - POS_EUL_DATA;
            s.idx = SLOT_EUL + {2'b00, off[3:2]};
        end else if (pos >= POS_ACC_DATA && pos <= POS_ACC_LAST) begin
            off   = pos - POS_ACC_DATA;
            s.idx = SLOT_ACC + {2'b00, off[3:2]};
        end else if (pos >= POS_GYR_DATA && pos <= POS_GYR_LAST) begin
            off   = pos - POS_GYR_DATA;
            s.idx = SLOT_GYR + {2'b00, off[3:2]};
        end else begin
            s.hit = 1'b0;
        end
        return s;
    endfunction

endpackage

### rtl/imufp_if.sv
// ----------------------------------------------------------------------------
// imufp_if
// valid/ready channels of the imu frame parser: received bytes in, frames out
// ----------------------------------------------------------------------------
interface imufp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface imufp_frame_if;
    logic        valid;
    logic        ready;
    logic [31:0] roll_bits;
    logic [31:0] pitch_bits;
    logic [31:0] yaw_bits;
    logic [31:0] accel_x_bits;
    logic [31:0] accel_y_bits;
    logic [31:0] accel_z_bits;
    logic [31:0] gyro_x_bits;
    logic [31:0] gyro_y_bits;
    logic [31:0] gyro_z_bits;
    logic        frame_status;

    modport source (
        output valid, output roll_bits, output pitch_bits, output yaw_bits,
        output accel_x_bits, output accel_y_bits, output accel_z_bits,
        output gyro_x_bits, output gyro_y_bits, output gyro_z_bits,
        output frame_status, input ready
    );
    modport sink (
        input valid, input roll_bits, input pitch_bits, input yaw_bits,
        input accel_x_bits, input accel_y_bits, input accel_z_bits,
        input gyro_x_bits, input gyro_y_bits, input gyro_z_bits,
        input frame_status, output ready
    );
endinterface

### rtl/imu_frame_parser_top.sv
// ----------------------------------------------------------------------------
// imu_frame_parser_top
// byte-serial parser for a fixed 50-byte measurement frame; emits nine sample
// words and a checksum status at each frame end
//
//   channel   dir  payload                                  request
//   i_rx      in   rx_byte                                  one received byte
//   o_frame   out  nine 32-bit sample words, frame_status   one parsed frame
//
// one byte per cycle while the core is not stalled; a byte is held in the input
// register until the core takes it
// a frame is loaded into the output register as the core takes its checksum byte
// synchronous active-low reset returns the parser to preamble hunting
// only a checksum byte stalls, and only while the output register is full
// ----------------------------------------------------------------------------
module imu_frame_parser_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    imufp_byte_if.sink    i_rx,
    imufp_frame_if.source o_frame
);

    logic                     core_valid;
    logic [7:0]               core_byte;
    logic                     core_take;
    logic                     res_load;
    logic                     res_free;
    imufp_pkg::t_frame_result res;

    imufp_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_take  (core_take),
        .o_valid (core_valid),
        .o_byte  (core_byte)
    );

    imufp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (core_valid),
        .i_byte      (core_byte),
        .i_res_ready (res_free),
        .o_take      (core_take),
        .o_load      (res_load),
        .o_res       (res)
    );

    imufp_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_load),
        .i_res   (res),
        .o_free  (res_free),
        .o_frame (o_frame)
    );

endmodule

### rtl/imufp_in_reg.sv
// ----------------------------------------------------------------------------
// imufp_in_reg
// input register: captures one received byte and holds it until the parser
// core takes it
// ----------------------------------------------------------------------------
module imufp_in_reg (
    input  logic        i_clk,
    input  logic        i_rst_n,
    imufp_byte_if.sink  i_rx,
    input  logic        i_take,
    output logic        o_valid,
    output logic [7:0]  o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       accept;

    assign i_rx.ready = !r_valid || i_take;
    assign accept     = i_rx.valid && i_rx.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_rx.rx_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

### rtl/imufp_core.sv
// ----------------------------------------------------------------------------
// imufp_core
// frame tracker: header check, running checksum and sample word assembly; while
// not stalled on a checksum byte it takes one byte per cycle
// ----------------------------------------------------------------------------
module imufp_core (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [7:0]               i_byte,
    input  logic                     i_res_ready,
    output logic                     o_take,
    output logic                     o_load,
    output imufp_pkg::t_frame_result o_res
);

    logic [imufp_pkg::POS_W-1:0] r_pos;
    logic [imufp_pkg::POS_W-1:0] n_pos;
    logic [7:0]                  r_sum;
    logic [7:0]                  n_sum;
    logic [imufp_pkg::NUM_WORDS-1:0][imufp_pkg::WORD_W-1:0] r_words;

    imufp_pkg::t_hdr_check hdr;
    imufp_pkg::t_slot      slot;
    logic                  hunting;
    logic                  at_end;
    logic [7:0]            sum_add;
    logic                  sum_ok;

    assign hunting = (r_pos == imufp_pkg::POS_HUNT) || (r_pos >= imufp_pkg::POS_LIMIT);
    assign at_end  = !hunting && (r_pos == imufp_pkg::POS_END);
    assign hdr     = imufp_pkg::f_header(r_pos);
    assign slot    = imufp_pkg::f_slot(r_pos);
    assign sum_add = r_sum + i_byte;
    assign sum_ok  = (sum_add == 8'h00);

    assign o_take = i_valid && (!at_end || i_res_ready);
    assign o_load = o_take && at_end;

    always_comb begin
        n_pos = r_pos;
        n_sum = r_sum;
        if (hunting) begin
            if (i_byte == imufp_pkg::BYTE_PREAMBLE) begin
                n_pos = imufp_pkg::POS_FIRST;
                n_sum = 8'h00;
            end else begin
                n_pos = imufp_pkg::POS_HUNT;
            end
        end else if (hdr.check && (i_byte != hdr.value)) begin
            n_pos = imufp_pkg::POS_HUNT;
            n_sum = 8'h00;
        end else if (at_end) begin
            n_pos = imufp_pkg::POS_HUNT;
            n_sum = 8'h00;
        end else begin
            n_pos = r_pos + 6'd1;
            n_sum = sum_add;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= imufp_pkg::POS_HUNT;
            r_sum <= 8'h00;
        end else if (o_take) begin
            r_pos <= n_pos;
            r_sum <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && !hunting && slot.hit) begin
            r_words[slot.idx] <= {r_words[slot.idx][imufp_pkg::WORD_W-9:0], i_byte};
        end
    end

    always_comb begin
        o_res.frame_status = sum_ok ? imufp_pkg::STATUS_OK : imufp_pkg::STATUS_BAD;
        o_res.words        = sum_ok ? r_words : '0;
    end

`ifndef ASSERT_OFF
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos < imufp_pkg::POS_LIMIT)
        else $error("frame position out of range");

    a_sum_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos <= imufp_pkg::POS_FIRST) |-> (r_sum == 8'h00))
        else $error("checksum not cleared at frame start");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_load |-> i_res_ready)
        else $error("result loaded into a full output register");

    a_end_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_load |=> (r_pos == imufp_pkg::POS_HUNT))
        else $error("parser not hunting after frame end");
`endif

endmodule

### rtl/imufp_out_reg.sv
// ----------------------------------------------------------------------------
// imufp_out_reg
// output register: holds one finished frame until the downstream side takes
// the request
// ----------------------------------------------------------------------------
module imufp_out_reg (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_load,
    input  imufp_pkg::t_frame_result i_res,
    output logic                     o_free,
    imufp_frame_if.source            o_frame
);

    logic                     r_valid;
    imufp_pkg::t_frame_result r_res;

    assign o_free = !r_valid || o_frame.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_frame.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_frame.valid        = r_valid;
    assign o_frame.roll_bits    = r_res.words[0];
    assign o_frame.pitch_bits   = r_res.words[1];
    assign o_frame.yaw_bits     = r_res.words[2];
    assign o_frame.accel_x_bits = r_res.words[3];
    assign o_frame.accel_y_bits = r_res.words[4];
    assign o_frame.accel_z_bits = r_res.words[5];
    assign o_frame.gyro_x_bits  = r_res.words[6];
    assign o_frame.gyro_y_bits  = r_res.words[7];
    assign o_frame.gyro_z_bits  = r_res.words[8];
    assign o_frame.frame_status = r_res.frame_status;

endmodule
